[sv/lus_pkg.sv]
package lus_pkg;

    localparam int ADDR_W = 7;
    localparam logic [3:0] COL_RHS = 4'd8;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [2:0]         index;
        logic signed [31:0] value;
        logic               singular;
        logic               last;
    } t_result;

    typedef struct packed {
        logic        we;
        t_addr       addr;
        logic [31:0] data;
        logic        start;
    } t_load;

    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        logic [31:0] u;
        u = a;
        return a[31] ? (~u + 32'd1) : u;
    endfunction

    // Apply sign to a magnitude and clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
        logic [31:0] lo;
        lo = m[31:0];
        if (neg) begin
            if (m > 64'h8000_0000) return 32'sh8000_0000;
            return -$signed(lo);
        end
        if (m > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return $signed(lo);
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647) return 32'sh7FFF_FFFF;
        if (d < -33'sd2147483648) return 32'sh8000_0000;
        return d[31:0];
    endfunction

endpackage

[sv/lus_div.sv]
module lus_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [31:0]   r_den;
    logic [31:0]   r_rem;
    logic          r_neg;
    logic          r_done;

    logic [32:0] rem_sh;
    logic        fits;
    logic [31:0] den_mag;

    assign den_mag = lus_pkg::mag32(i_den);
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign fits    = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= NW'({lus_pkg::mag32(i_num), FRAC_BITS'(0)}) + NW'(den_mag >> 1);
                r_den  <= den_mag;
                r_rem  <= '0;
                r_neg  <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                // one quotient bit per cycle, restoring
                r_rem <= fits ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
                r_num <= {r_num[NW-2:0], fits};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = lus_pkg::sat_mag(64'(r_num), r_neg);

endmodule

[sv/lus_core.sv]
module lus_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_order,
    input  lus_pkg::t_load    i_load,
    output logic              o_idle,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output lus_pkg::t_result  o_res
);

    localparam int DEPTH = 2 ** lus_pkg::ADDR_W;

    typedef enum logic [4:0] {
        S_IDLE, S_COPY_RD, S_COPY_WR, S_PIV_RD, S_PIV_WT, S_ROW_CHK, S_M_DATA, S_DIV_M,
        S_I_CHK, S_I_B, S_I_ACC, S_I_SUB, S_X_RD, S_X_WT, S_T_CHK, S_T_A, S_T_B,
        S_T_SUB, S_D_WT, S_D_RUN, S_E_RD, S_E_OUT, S_SING
    } t_state;

    logic [31:0] lmem [DEPTH];
    logic [31:0] wmem [DEPTH];

    t_state             r_st;
    logic [3:0]         r_r, r_c, r_i;
    logic               r_back;
    logic [31:0]        r_lq, r_wq;
    logic signed [31:0] r_piv, r_m, r_opb, r_acc;
    logic [63:0]        r_prod;
    logic               r_neg;

    logic                 l_re, w_re, w_we, div_go, div_done;
    lus_pkg::t_addr       l_ra, w_ra, w_wa;
    logic [31:0]          w_wd;
    logic signed [31:0]   div_a, div_b, div_q, scaled, diff;
    logic [63:0]          rounded;
    logic                 t_more;

    function automatic lus_pkg::t_addr ad(input logic [3:0] r, input logic [3:0] c);
        return {r[2:0], c};
    endfunction

    assign rounded = (r_prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign scaled  = lus_pkg::sat_mag(rounded, r_neg);
    assign diff    = lus_pkg::sat_sub(r_acc, scaled);
    assign t_more  = r_back ? (r_c < i_order) : (r_c < r_r);

    lus_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_go),
        .i_num  (div_a),
        .i_den  (div_b),
        .o_done (div_done),
        .o_quot (div_q)
    );

    always_comb begin
        l_re = 1'b0; l_ra = '0;
        w_re = 1'b0; w_ra = '0;
        w_we = 1'b0; w_wa = '0; w_wd = '0;
        div_go = 1'b0; div_a = r_acc; div_b = r_wq;
        case (r_st)
            S_COPY_RD: begin l_re = 1'b1; l_ra = ad(r_r, r_c); end
            S_COPY_WR: begin w_we = 1'b1; w_wa = ad(r_r, r_c); w_wd = r_lq; end
            S_PIV_RD:  begin w_re = 1'b1; w_ra = ad(r_c, r_c); end
            S_ROW_CHK: begin w_re = r_r < i_order; w_ra = ad(r_r, r_c); end
            S_M_DATA:  begin div_go = 1'b1; div_a = r_wq; div_b = r_piv; end
            S_DIV_M:   begin w_we = div_done; w_wa = ad(r_r, r_c); w_wd = div_q; end
            S_I_CHK:   begin w_re = r_i < i_order; w_ra = ad(r_c, r_i); end
            S_I_B:     begin w_re = 1'b1; w_ra = ad(r_r, r_i); end
            S_I_SUB:   begin w_we = 1'b1; w_wa = ad(r_r, r_i); w_wd = diff; end
            S_X_RD:    begin w_re = 1'b1; w_ra = ad(r_r, lus_pkg::COL_RHS); end
            S_T_CHK: begin
                if (t_more) begin
                    w_re = 1'b1; w_ra = ad(r_c, lus_pkg::COL_RHS);
                end else if (!r_back) begin
                    w_we = 1'b1; w_wa = ad(r_r, lus_pkg::COL_RHS); w_wd = r_acc;
                end else begin
                    w_re = 1'b1; w_ra = ad(r_r, r_r);
                end
            end
            S_T_A:     begin w_re = 1'b1; w_ra = ad(r_r, r_c); end
            S_D_WT:    begin div_go = 1'b1; div_a = r_acc; div_b = r_wq; end
            S_D_RUN: begin
                w_we = div_done; w_wa = ad(r_r, lus_pkg::COL_RHS); w_wd = div_q;
            end
            S_E_RD:    begin w_re = 1'b1; w_ra = ad(r_r, lus_pkg::COL_RHS); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we) lmem[i_load.addr] <= i_load.data;
        if (l_re) r_lq <= lmem[l_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) wmem[w_wa] <= w_wd;
        if (w_re) r_wq <= wmem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_r    <= '0;
            r_c    <= '0;
            r_i    <= '0;
            r_back <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: if (i_load.start) begin
                    r_r  <= '0;
                    r_c  <= '0;
                    r_st <= S_COPY_RD;
                end
                S_COPY_RD: r_st <= S_COPY_WR;
                S_COPY_WR: begin
                    r_st <= S_COPY_RD;
                    if (r_c == lus_pkg::COL_RHS) begin
                        r_c <= '0;
                        r_r <= r_r + 4'd1;
                        if (r_r == i_order - 4'd1) r_st <= S_PIV_RD;
                    end else if (r_c == i_order - 4'd1) begin
                        r_c <= lus_pkg::COL_RHS;
                    end else begin
                        r_c <= r_c + 4'd1;
                    end
                end
                S_PIV_RD: r_st <= S_PIV_WT;
                S_PIV_WT: begin
                    r_piv <= r_wq;
                    r_r   <= r_c + 4'd1;
                    r_st  <= (r_wq == '0) ? S_SING : S_ROW_CHK;
                end
                S_ROW_CHK: begin
                    if (r_r < i_order) begin
                        r_st <= S_M_DATA;
                    end else if (r_c == i_order - 4'd1) begin
                        r_back <= 1'b0;
                        r_r    <= '0;
                        r_st   <= S_X_RD;
                    end else begin
                        r_c  <= r_c + 4'd1;
                        r_st <= S_PIV_RD;
                    end
                end
                S_M_DATA: r_st <= S_DIV_M;
                S_DIV_M: if (div_done) begin
                    r_m  <= div_q;
                    r_i  <= r_c + 4'd1;
                    r_st <= S_I_CHK;
                end
                S_I_CHK: begin
                    if (r_i < i_order) begin
                        r_st <= S_I_B;
                    end else begin
                        r_r  <= r_r + 4'd1;
                        r_st <= S_ROW_CHK;
                    end
                end
                S_I_B: begin
                    r_opb <= r_wq;
                    r_st  <= S_I_ACC;
                end
                S_I_ACC: begin
                    r_acc  <= r_wq;
                    r_prod <= lus_pkg::mag32(r_m) * lus_pkg::mag32(r_opb);
                    r_neg  <= r_m[31] ^ r_opb[31];
                    r_st   <= S_I_SUB;
                end
                S_I_SUB: begin
                    r_i  <= r_i + 4'd1;
                    r_st <= S_I_CHK;
                end
                S_X_RD: r_st <= S_X_WT;
                S_X_WT: begin
                    r_acc <= r_wq;
                    r_c   <= r_back ? r_r + 4'd1 : 4'd0;
                    r_st  <= S_T_CHK;
                end
                S_T_CHK: begin
                    if (t_more) begin
                        r_st <= S_T_A;
                    end else if (!r_back) begin
                        r_st <= S_X_RD;
                        if (r_r == i_order - 4'd1) r_back <= 1'b1;
                        else r_r <= r_r + 4'd1;
                    end else begin
                        r_st <= S_D_WT;
                    end
                end
                S_T_A: begin
                    r_m  <= r_wq;
                    r_st <= S_T_B;
                end
                S_T_B: begin
                    r_prod <= lus_pkg::mag32(r_m) * lus_pkg::mag32(r_wq);
                    r_neg  <= r_m[31] ^ r_wq[31];
                    r_st   <= S_T_SUB;
                end
                S_T_SUB: begin
                    r_acc <= diff;
                    r_c   <= r_c + 4'd1;
                    r_st  <= S_T_CHK;
                end
                S_D_WT: r_st <= S_D_RUN;
                S_D_RUN: if (div_done) begin
                    if (r_r == '0) begin
                        r_st <= S_E_RD;
                    end else begin
                        r_r  <= r_r - 4'd1;
                        r_st <= S_X_RD;
                    end
                end
                S_E_RD: r_st <= S_E_OUT;
                S_E_OUT: if (i_res_ready) begin
                    if (r_r == i_order - 4'd1) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_r  <= r_r + 4'd1;
                        r_st <= S_E_RD;
                    end
                end
                S_SING: if (i_res_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_idle      = r_st == S_IDLE;
    assign o_res_valid = (r_st == S_E_OUT) || (r_st == S_SING);

    always_comb begin
        o_res          = '0;
        o_res.last     = 1'b1;
        o_res.singular = 1'b1;
        if (r_st == S_E_OUT) begin
            o_res.index    = r_r[2:0];
            o_res.value    = r_wq;
            o_res.singular = 1'b0;
            o_res.last     = r_r == i_order - 4'd1;
        end
    end

endmodule

[sv/lu_linear_system_solver_unit.sv]
// Solves A x = b for an n-by-n system (n from the size register, 1 to 8) in signed
// fixed point by LU elimination without pivoting. Load A and b one entry per beat,
// one beat per cycle; the beat with tlast set starts the solve, and the input stalls
// until the last solution beat has been handed to the output register. The solve
// copies the loaded entries into a working memory (a read state, then a write state,
// per entry), then runs one read-modify-write at a time through a single-ported
// working memory: each multiplier and each back-substitution quotient waits on an
// iterative divider, and each update step reads its operands, multiplies and writes
// back the difference. A zero pivot yields a single result beat flagged singular.
module lu_linear_system_solver_unit #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row_index[2:0], col_index[6:3], entry_value[38:7]
    input  logic        s_axis_tlast,   // start_solve
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // solution_index[2:0], solution_value[34:3]
    output logic        m_axis_tuser,   // singular
    output logic        m_axis_tlast    // last_result
);

    localparam logic [3:0] ORDER_CAP = (MAX_ORDER < 8) ? 4'(MAX_ORDER) : 4'd8;

    logic [3:0]       r_size;
    logic [3:0]       order;
    logic             core_idle, res_valid, res_ready, in_acc;
    logic [2:0]       row;
    logic [3:0]       col;
    lus_pkg::t_load   load;
    lus_pkg::t_result res, r_out;
    logic             r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_size <= 4'd4;
        else if (i_cfg_we) r_size <= i_cfg_wdata;
    end

    always_comb begin
        order = r_size;
        if (r_size == '0) order = 4'd1;
        else if (r_size > ORDER_CAP) order = ORDER_CAP;
    end

    assign s_axis_tready = core_idle;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign row           = s_axis_tdata[2:0];
    assign col           = s_axis_tdata[6:3];

    // drop entries outside the system; the b column maps to the spare column
    always_comb begin
        load.we    = in_acc && ({1'b0, row} < order) && (col <= order);
        load.addr  = (col < order) ? {row, col} : {row, lus_pkg::COL_RHS};
        load.data  = s_axis_tdata[38:7];
        load.start = in_acc && s_axis_tlast;
    end

    lus_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_order    (order),
        .i_load     (load),
        .o_idle     (core_idle),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_out <= res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.value, r_out.index};
    assign m_axis_tuser  = r_out.singular;
    assign m_axis_tlast  = r_out.last;

endmodule
